>>> rtl/core/ssc_pkg.sv
// Shared types, constants and helpers for the sphere/segment contact block.
// Used by the front, queue, back and top modules under rtl/core; depends on nothing else.
package ssc_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned RadW      = 30;
  localparam int unsigned NormW     = 16;
  localparam int unsigned ImpactW   = 31;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned FifoDepth = 4;
  // Quotient bits of the projection divide and of the normal divide.
  localparam int unsigned TDivSteps = 31;
  localparam int unsigned NDivSteps = 15;
  // One result bit per step of the square root.
  localparam int unsigned SqrtSteps = 31;

  localparam logic [RadW-1:0] OwnRadiusRst = RadW'(65536);
  localparam logic            ResolveRst   = 1'b0;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OWN_RADIUS = 1'b0,
    REG_RESOLVE    = 1'b1
  } cfg_reg_e;

  // Where the closest point lies: at the start, at the end, or between.
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_END   = 2'd1,
    KIND_DIV   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [2:0][31:0] c;
    logic [2:0][31:0] a;
    logic [2:0][32:0] d;
    logic [29:0]      rr;
    kind_e            kind;
  } ssc_geo_t;

  typedef struct packed {
    ssc_geo_t    geo;
    logic [31:0] uw;
    logic [31:0] ud;
  } ssc_job_t;

  typedef struct packed {
    logic [2:0][31:0] c;
    logic [2:0][32:0] p;
    logic [2:0]       neg;
    logic [2:0][30:0] av;
    logic [29:0]      rr;
    logic             hit;
  } ssc_hit_t;

  typedef struct packed {
    ssc_hit_t    h;
    logic [30:0] l;
  } ssc_nrm_t;

  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    logic [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -36'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/ssc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a carried tag.
// The high part of the dividend must be below the divisor. Depends on nothing.
module ssc_div #(
  parameter int unsigned DW = 32,
  parameter int unsigned QW = 31,
  parameter int unsigned TW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] hi_i,
  input  logic [QW-1:0] lo_i,
  input  logic [DW-1:0] div_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);

  logic [QW-1:0]          v_q, v_in;
  logic [DW-1:0]          rem_q [QW], rem_in [QW], rem_d [QW];
  logic [DW-1:0]          div_q [QW], div_in [QW];
  logic [QW-1:0]          qb_q [QW], qb_in [QW], qb_d [QW];
  logic [TW-1:0]          tag_q [QW], tag_in [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign v_in[k]   = valid_i;
      assign rem_in[k] = hi_i;
      assign div_in[k] = div_i;
      assign qb_in[k]  = lo_i;
      assign tag_in[k] = tag_i;
    end else begin : g_next
      assign v_in[k]   = v_q[k-1];
      assign rem_in[k] = rem_q[k-1];
      assign div_in[k] = div_q[k-1];
      assign qb_in[k]  = qb_q[k-1];
      assign tag_in[k] = tag_q[k-1];
    end

    always_comb begin
      logic [DW:0] r2;
      logic [DW:0] dif;
      logic        ge;
      r2  = {rem_in[k], qb_in[k][QW-1]};
      dif = r2 - {1'b0, div_in[k]};
      ge  = (r2 >= {1'b0, div_in[k]});
      rem_d[k] = ge ? dif[DW-1:0] : r2[DW-1:0];
      qb_d[k]  = {qb_in[k][QW-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d[k];
        div_q[k] <= div_in[k];
        qb_q[k]  <= qb_d[k];
        tag_q[k] <= tag_in[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= v_in;
    end
  end

  assign valid_o = v_q[QW-1];
  assign quo_o   = qb_q[QW-1];
  assign tag_o   = tag_q[QW-1];

endmodule

>>> rtl/core/ssc_front.sv
// Front part: differences, dot products, classification of the closest point
// and scaling of the projection ratio. Depends on ssc_pkg.
module ssc_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [2:0][31:0]       c_i,
  input  logic [2:0][31:0]       a_i,
  input  logic [2:0][31:0]       b_i,
  input  logic [29:0]            rr_i,
  output logic                   job_valid_o,
  input  logic                   job_ready_i,
  output ssc_pkg::ssc_job_t      job_o
);

  logic [5:1] v_q;
  logic       en;

  ssc_pkg::ssc_geo_t geo1_q, geo2_q, geo3_q, geo4_q, geo5_q, geo1_d, geo4_d;
  logic signed [30:0] ds_q [3], ws_q [3], ds_d [3], ws_d [3];
  logic signed [61:0] wp_q [3], dp_q [3];
  logic signed [63:0] wd3_q, dd3_q, wd4_q, dd4_q;
  logic [4:0]         s4_q, s_d;
  ssc_pkg::kind_e     kind_d;
  logic [31:0]        uw5_q, ud5_q;

  // The whole front moves together; it holds only when its last stage is blocked.
  assign en      = !v_q[5] || job_ready_i;
  assign ready_o = en;

  always_comb begin
    logic signed [32:0] w;
    geo1_d      = '0;
    geo1_d.c    = c_i;
    geo1_d.a    = a_i;
    geo1_d.rr   = rr_i;
    geo1_d.kind = ssc_pkg::KIND_START;
    for (int i = 0; i < 3; i++) begin
      geo1_d.d[i] = $signed({b_i[i][31], b_i[i]}) - $signed({a_i[i][31], a_i[i]});
      w           = $signed({c_i[i][31], c_i[i]}) - $signed({a_i[i][31], a_i[i]});
      // Dropping the two low bits is a floor division by four.
      ds_d[i] = $signed(geo1_d.d[i][32:2]);
      ws_d[i] = w[32:2];
    end
  end

  always_comb begin
    s_d = '0;
    for (int j = 0; j < 30; j++) begin
      if (dd3_q[32+j]) s_d = 5'(j + 1);
    end
    if (dd3_q == '0 || wd3_q <= 0) begin
      kind_d = ssc_pkg::KIND_START;
    end else if (wd3_q >= dd3_q) begin
      kind_d = ssc_pkg::KIND_END;
    end else begin
      kind_d = ssc_pkg::KIND_DIV;
    end
    geo4_d      = geo3_q;
    geo4_d.kind = kind_d;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      geo1_q <= geo1_d;
      for (int i = 0; i < 3; i++) begin
        ds_q[i] <= ds_d[i];
        ws_q[i] <= ws_d[i];
        wp_q[i] <= ws_q[i] * ds_q[i];
        dp_q[i] <= ds_q[i] * ds_q[i];
      end
      geo2_q <= geo1_q;
      wd3_q  <= 64'(wp_q[0]) + 64'(wp_q[1]) + 64'(wp_q[2]);
      dd3_q  <= 64'(dp_q[0]) + 64'(dp_q[1]) + 64'(dp_q[2]);
      geo3_q <= geo2_q;
      wd4_q  <= wd3_q;
      dd4_q  <= dd3_q;
      s4_q   <= s_d;
      geo4_q <= geo4_d;
      uw5_q  <= 32'(wd4_q[61:0] >> s4_q);
      ud5_q  <= 32'(dd4_q[61:0] >> s4_q);
      geo5_q <= geo4_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[4:1], valid_i};
    end
  end

  assign job_valid_o = v_q[5];
  assign job_o.geo   = geo5_q;
  assign job_o.uw    = uw5_q;
  assign job_o.ud    = ud5_q;

endmodule

>>> rtl/core/ssc_fifo.sv
// Short request queue between the front and back parts.
// Depends on ssc_pkg for the entry type.
module ssc_fifo #(
  parameter int unsigned DEPTH = ssc_pkg::FifoDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ssc_pkg::ssc_job_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output ssc_pkg::ssc_job_t data_o,
  output logic              empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  ssc_pkg::ssc_job_t mem_q [DEPTH];
  logic [PtrW-1:0]   wptr_q, rptr_q;
  logic [CntW-1:0]   cnt_q;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/ssc_back.sv
// Back part: projection divide, distance test, square root, normal divide,
// contact and resolved centre. Depends on ssc_pkg and ssc_div.
module ssc_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [29:0]              own_radius_i,
  input  logic                     resolve_i,
  input  logic                     job_valid_i,
  output logic                     job_pop_o,
  input  ssc_pkg::ssc_job_t        job_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic                     hit_o,
  output logic [2:0][15:0]         normal_o,
  output logic [30:0]              impact_o,
  output logic [2:0][31:0]         contact_o,
  output logic [2:0][31:0]         resolved_o
);

  localparam int unsigned SN = ssc_pkg::SqrtSteps;

  logic en;
  logic out_v_q;

  // The back pipeline moves as one; it holds while a result waits to be taken.
  assign en        = !out_v_q || ready_i;
  assign job_pop_o = en && job_valid_i;

  // Projection ratio t.
  logic              td_v;
  logic [30:0]       td_q;
  ssc_pkg::ssc_geo_t td_geo;

  ssc_div #(.DW(32), .QW(ssc_pkg::TDivSteps), .TW($bits(ssc_pkg::ssc_geo_t))) u_tdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (job_pop_o),
    .hi_i    ({1'b0, job_i.uw[31:1]}),
    .lo_i    ({job_i.uw[0], 30'd0}),
    .div_i   (job_i.ud),
    .tag_i   (job_i.geo),
    .valid_o (td_v),
    .quo_o   (td_q),
    .tag_o   (td_geo)
  );

  logic              m_v_q, p_v_q, v_v_q, s_v_q, t_v_q;
  ssc_pkg::ssc_geo_t m_geo_q;
  logic signed [64:0] m_prod_q [3];
  logic [2:0][31:0]  p_c_q, v_c_q, s_c_q;
  logic [2:0][32:0]  p_p_q, v_p_q, s_p_q, p_d;
  logic [29:0]       p_rr_q, v_rr_q, s_rr_q;
  logic [2:0]        v_neg_q, s_neg_q;
  logic [2:0][30:0]  v_av_q, s_av_q;
  logic              v_near_q, s_near_q, near_d;
  logic [2:0]        neg_d;
  logic [2:0][30:0]  av_d;
  logic [61:0]       s_sq_q [3];
  logic [61:0]       s_r2_q;
  ssc_pkg::ssc_hit_t t_hit_q;
  logic [61:0]       t_x_q;
  logic [63:0]       sum_d;
  logic [30:0]       r_p, r_s;

  assign r_p = 31'(own_radius_i) + 31'(p_rr_q);
  assign r_s = 31'(own_radius_i) + 31'(s_rr_q);

  always_comb begin
    logic signed [64:0] sh;
    for (int i = 0; i < 3; i++) begin
      sh = m_prod_q[i] >>> 30;
      unique case (m_geo_q.kind)
        ssc_pkg::KIND_START: p_d[i] = {m_geo_q.a[i][31], m_geo_q.a[i]};
        ssc_pkg::KIND_END:   p_d[i] = {m_geo_q.a[i][31], m_geo_q.a[i]} + m_geo_q.d[i];
        default:             p_d[i] = {m_geo_q.a[i][31], m_geo_q.a[i]} + sh[32:0];
      endcase
    end
  end

  always_comb begin
    logic signed [33:0] v;
    logic [33:0]        av;
    near_d = 1'b1;
    for (int i = 0; i < 3; i++) begin
      v  = $signed({{2{p_c_q[i][31]}}, p_c_q[i]}) - $signed({p_p_q[i][32], p_p_q[i]});
      av = v[33] ? 34'(-v) : 34'(v);
      neg_d[i] = v[33];
      av_d[i]  = av[30:0];
      if (av >= 34'(r_p)) near_d = 1'b0;
    end
  end

  assign sum_d = 64'(s_sq_q[0]) + 64'(s_sq_q[1]) + 64'(s_sq_q[2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_geo_q <= td_geo;
      for (int i = 0; i < 3; i++) begin
        m_prod_q[i] <= $signed(td_geo.d[i]) * $signed({1'b0, td_q});
      end
      p_c_q  <= m_geo_q.c;
      p_p_q  <= p_d;
      p_rr_q <= m_geo_q.rr;
      v_c_q    <= p_c_q;
      v_p_q    <= p_p_q;
      v_rr_q   <= p_rr_q;
      v_neg_q  <= neg_d;
      v_av_q   <= av_d;
      v_near_q <= near_d;
      s_c_q    <= v_c_q;
      s_p_q    <= v_p_q;
      s_rr_q   <= v_rr_q;
      s_neg_q  <= v_neg_q;
      s_av_q   <= v_av_q;
      s_near_q <= v_near_q;
      for (int i = 0; i < 3; i++) begin
        s_sq_q[i] <= 62'(v_av_q[i]) * 62'(v_av_q[i]);
      end
      s_r2_q <= 62'(31'(own_radius_i) + 31'(v_rr_q)) * 62'(31'(own_radius_i) + 31'(v_rr_q));
      t_hit_q.c   <= s_c_q;
      t_hit_q.p   <= s_p_q;
      t_hit_q.neg <= s_neg_q;
      t_hit_q.av  <= s_av_q;
      t_hit_q.rr  <= s_rr_q;
      t_hit_q.hit <= s_near_q && (r_s != '0) && (sum_d < 64'(s_r2_q));
      t_x_q       <= sum_d[61:0];
    end
  end

  // Square root, two radicand bits per stage.
  logic [SN-1:0]     q_v_q, q_v_in;
  logic [32:0]       q_rem_q [SN], q_rem_in [SN], q_rem_d [SN];
  logic [30:0]       q_root_q [SN], q_root_in [SN], q_root_d [SN];
  logic [61:0]       q_x_q [SN], q_x_in [SN];
  ssc_pkg::ssc_hit_t q_tag_q [SN], q_tag_in [SN];

  for (genvar k = 0; k < SN; k++) begin : g_sqrt
    if (k == 0) begin : g_first
      assign q_v_in[k]    = t_v_q;
      assign q_rem_in[k]  = '0;
      assign q_root_in[k] = '0;
      assign q_x_in[k]    = t_x_q;
      assign q_tag_in[k]  = t_hit_q;
    end else begin : g_next
      assign q_v_in[k]    = q_v_q[k-1];
      assign q_rem_in[k]  = q_rem_q[k-1];
      assign q_root_in[k] = q_root_q[k-1];
      assign q_x_in[k]    = q_x_q[k-1];
      assign q_tag_in[k]  = q_tag_q[k-1];
    end

    always_comb begin
      logic [34:0] r4;
      logic [34:0] trial;
      logic [34:0] dif;
      logic        ge;
      r4    = {q_rem_in[k], q_x_in[k][61:60]};
      trial = {2'b00, q_root_in[k], 2'b01};
      dif   = r4 - trial;
      ge    = (r4 >= trial);
      q_rem_d[k]  = ge ? dif[32:0] : r4[32:0];
      q_root_d[k] = {q_root_in[k][29:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        q_rem_q[k]  <= q_rem_d[k];
        q_root_q[k] <= q_root_d[k];
        q_x_q[k]    <= {q_x_in[k][59:0], 2'b00};
        q_tag_q[k]  <= q_tag_in[k];
      end
    end
  end

  // Normal components, one divider per axis sharing the distance as divisor.
  logic [30:0]       len;
  ssc_pkg::ssc_nrm_t nd_tag_in, nd_tag;
  logic              nd_v;
  logic [14:0]       nd_q [3];
  logic [45:0]       num [3];

  assign len           = q_root_q[SN-1];
  assign nd_tag_in.h   = q_tag_q[SN-1];
  assign nd_tag_in.l   = len;

  for (genvar i = 0; i < 3; i++) begin : g_ndiv
    assign num[i] = {1'b0, q_tag_q[SN-1].av[i], 14'd0} + 46'(len[30:1]);
    if (i == 0) begin : g_tagged
      ssc_div #(.DW(32), .QW(ssc_pkg::NDivSteps), .TW($bits(ssc_pkg::ssc_nrm_t))) u_ndiv (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .valid_i (q_v_q[SN-1]),
        .hi_i    ({1'b0, num[i][45:15]}),
        .lo_i    (num[i][14:0]),
        .div_i   ({1'b0, len}),
        .tag_i   (nd_tag_in),
        .valid_o (nd_v),
        .quo_o   (nd_q[i]),
        .tag_o   (nd_tag)
      );
    end else begin : g_plain
      ssc_div #(.DW(32), .QW(ssc_pkg::NDivSteps), .TW(1)) u_ndiv (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .valid_i (q_v_q[SN-1]),
        .hi_i    ({1'b0, num[i][45:15]}),
        .lo_i    (num[i][14:0]),
        .div_i   ({1'b0, len}),
        .tag_i   (1'b0),
        .valid_o (),
        .quo_o   (nd_q[i]),
        .tag_o   ()
      );
    end
  end

  logic              n_v_q, r_v_q, c_v_q;
  ssc_pkg::ssc_nrm_t n_tag_q, r_tag_q, c_tag_q;
  logic signed [15:0] n_q [3], r_n_q [3], c_n_q [3];
  logic signed [46:0] r_pr_q [3], r_po_q [3];
  logic signed [35:0] c_ct_q [3];
  logic signed [32:0] c_off_q [3];

  always_ff @(posedge clk_i) begin
    logic signed [46:0] rnd_r;
    logic signed [46:0] rnd_o;
    if (en) begin
      n_tag_q <= nd_tag;
      for (int i = 0; i < 3; i++) begin
        if (nd_tag.l == '0) begin
          n_q[i] <= '0;
        end else if (nd_tag.h.neg[i]) begin
          n_q[i] <= -$signed({1'b0, nd_q[i]});
        end else begin
          n_q[i] <= $signed({1'b0, nd_q[i]});
        end
      end
      r_tag_q <= n_tag_q;
      for (int i = 0; i < 3; i++) begin
        r_n_q[i]  <= n_q[i];
        r_pr_q[i] <= n_q[i] * $signed({1'b0, n_tag_q.h.rr});
        r_po_q[i] <= n_q[i] * $signed({1'b0, own_radius_i});
      end
      c_tag_q <= r_tag_q;
      for (int i = 0; i < 3; i++) begin
        rnd_r = r_pr_q[i] + 47'sd8192;
        rnd_o = r_po_q[i] + 47'sd8192;
        c_n_q[i]   <= r_n_q[i];
        c_ct_q[i]  <= 36'($signed(r_tag_q.h.p[i])) + 36'($signed(rnd_r[46:14]));
        c_off_q[i] <= rnd_o[46:14];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [35:0] rs;
    if (en) begin
      hit_o    <= c_tag_q.h.hit;
      impact_o <= c_tag_q.h.hit ? (31'(own_radius_i) + 31'(c_tag_q.h.rr) - c_tag_q.l) : '0;
      for (int i = 0; i < 3; i++) begin
        rs = resolve_i ? (c_ct_q[i] + 36'(c_off_q[i]))
                       : 36'($signed(c_tag_q.h.c[i]));
        if (c_tag_q.h.hit) begin
          normal_o[i]   <= c_n_q[i];
          contact_o[i]  <= ssc_pkg::sat32(c_ct_q[i]);
          resolved_o[i] <= ssc_pkg::sat32(rs);
        end else begin
          normal_o[i]   <= '0;
          contact_o[i]  <= '0;
          resolved_o[i] <= c_tag_q.h.c[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q   <= 1'b0;
      p_v_q   <= 1'b0;
      v_v_q   <= 1'b0;
      s_v_q   <= 1'b0;
      t_v_q   <= 1'b0;
      q_v_q   <= '0;
      n_v_q   <= 1'b0;
      r_v_q   <= 1'b0;
      c_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      m_v_q   <= td_v;
      p_v_q   <= m_v_q;
      v_v_q   <= p_v_q;
      s_v_q   <= v_v_q;
      t_v_q   <= s_v_q;
      q_v_q   <= q_v_in;
      n_v_q   <= nd_v;
      r_v_q   <= n_v_q;
      c_v_q   <= r_v_q;
      out_v_q <= c_v_q;
    end
  end

  assign valid_o = out_v_q;

endmodule

>>> rtl/core/sphere_segment_contact.sv
// Sphere against segment/capsule contact test. The back part holds the 31-stage
// projection divider, the 31-stage square root and the 15-stage normal dividers.
// One request is accepted per cycle while the output is taken.
// Reset (asynchronous, active low) empties all stages and the queue and loads
// own_radius with 1.0 and resolve_enable with 0.
module sphere_segment_contact #(
  parameter int unsigned FIFO_DEPTH = ssc_pkg::FifoDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // center_x/y/z, seg_start_x/y/z, seg_end_x/y/z, rival_radius, zero pad
  input  logic [319:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // normal_x/y/z, impact, contact_x/y/z, resolved_x/y/z, zero pad
  output logic [271:0] m_axis_tdata,
  // hit
  output logic         m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic [ssc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [29:0]  cfg_data_i
);

  logic [29:0]       own_radius_q;
  logic              resolve_q;
  logic [2:0][31:0]  c, a, b;
  ssc_pkg::ssc_job_t f_job, q_job;
  logic              f_valid, q_full, q_empty, q_pop;
  logic [2:0][15:0]  normal;
  logic [30:0]       impact;
  logic [2:0][31:0]  contact, resolved;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_radius_q <= ssc_pkg::OwnRadiusRst;
      resolve_q    <= ssc_pkg::ResolveRst;
    end else if (cfg_we_i) begin
      unique case (ssc_pkg::cfg_reg_e'(cfg_idx_i))
        ssc_pkg::REG_OWN_RADIUS: own_radius_q <= cfg_data_i;
        ssc_pkg::REG_RESOLVE:    resolve_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c[i] = s_axis_tdata[32*i +: 32];
      a[i] = s_axis_tdata[96 + 32*i +: 32];
      b[i] = s_axis_tdata[192 + 32*i +: 32];
    end
  end

  ssc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .c_i         (c),
    .a_i         (a),
    .b_i         (b),
    .rr_i        (s_axis_tdata[317:288]),
    .job_valid_o (f_valid),
    .job_ready_i (!q_full),
    .job_o       (f_job)
  );

  ssc_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid && !q_full),
    .data_i  (f_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_job),
    .empty_o (q_empty)
  );

  ssc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .own_radius_i (own_radius_q),
    .resolve_i    (resolve_q),
    .job_valid_i  (!q_empty),
    .job_pop_o    (q_pop),
    .job_i        (q_job),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .hit_o        (m_axis_tuser),
    .normal_o     (normal),
    .impact_o     (impact),
    .contact_o    (contact),
    .resolved_o   (resolved)
  );

  assign m_axis_tdata = {1'b0, resolved[2], resolved[1], resolved[0],
                         contact[2], contact[1], contact[0], impact,
                         normal[2], normal[1], normal[0]};

endmodule

>>> rtl/core/ssc_checker.sv
// Port-level checks for sphere_segment_contact, attached by the bind below.
// Depends only on the top level's ports.
module ssc_port_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [271:0] m_axis_tdata,
  input logic         m_axis_tuser
);

  // A stalled result must hold.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result shown during reset");

  // A miss carries no normal, depth or contact.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[174:0] == '0)
    else $error("miss with non-zero contact fields");

  // The distance is below the radius sum on a hit, so the depth is positive.
  a_hit_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[78:48] != '0)
    else $error("hit with zero depth");

  a_normal_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ($signed(m_axis_tdata[15:0]) <= 16'sd16384) &&
      ($signed(m_axis_tdata[15:0]) >= -16'sd16384) &&
      ($signed(m_axis_tdata[31:16]) <= 16'sd16384) &&
      ($signed(m_axis_tdata[31:16]) >= -16'sd16384) &&
      ($signed(m_axis_tdata[47:32]) <= 16'sd16384) &&
      ($signed(m_axis_tdata[47:32]) >= -16'sd16384))
    else $error("normal component out of range");

endmodule

bind sphere_segment_contact ssc_port_checker u_ssc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
